[design/kdlp_pkg.sv]
// ----------------------------------------------------------------------------
// kdlp_pkg
// shared types and constants for the key debounce and long press unit
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

  localparam int unsigned NUM_KEYS  = 3;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned LONG_W    = 16;
  localparam int unsigned EVENT_W   = 2;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned TDATA_W   = 8;

  localparam logic [MASK_W-1:0] KEYS_MASK = MASK_W'((1 << NUM_KEYS) - 1);

  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd10;
  localparam logic [LONG_W-1:0]   LONG_PRESS_RST    = 16'd150;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_PERIOD = 1'b0;
  localparam logic REG_LONG_PRESS    = 1'b1;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CONFIRM = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HELD    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd3;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_DOWN = 2'd1;
  localparam logic [EVENT_W-1:0] EV_UP   = 2'd2;
  localparam logic [EVENT_W-1:0] EV_LONG = 2'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0] sample_period;
    logic [LONG_W-1:0]   long_press_samples;
  } cfg_t;

endpackage

`default_nettype wire

[design/kdlp_cfg.sv]
// ----------------------------------------------------------------------------
// kdlp_cfg
// apb register file holding the sample period and the long press count
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kdlp_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [kdlp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [kdlp_pkg::APB_DATA_W-1:0]  prdata,
  output kdlp_pkg::cfg_t                        cfg
);

  logic [kdlp_pkg::PERIOD_W-1:0] sample_period_r;
  logic [kdlp_pkg::LONG_W-1:0]   long_press_r;
  logic                          wr_en;
  logic                          reg_sel;

  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= kdlp_pkg::SAMPLE_PERIOD_RST;
      long_press_r    <= kdlp_pkg::LONG_PRESS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        kdlp_pkg::REG_SAMPLE_PERIOD: sample_period_r <= pwdata[kdlp_pkg::PERIOD_W-1:0];
        kdlp_pkg::REG_LONG_PRESS:    long_press_r    <= pwdata[kdlp_pkg::LONG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kdlp_pkg::REG_SAMPLE_PERIOD:
        prdata = kdlp_pkg::APB_DATA_W'(sample_period_r);
      kdlp_pkg::REG_LONG_PRESS:
        prdata = kdlp_pkg::APB_DATA_W'(long_press_r);
      default:
        prdata = '0;
    endcase
  end

  assign cfg.sample_period      = sample_period_r;
  assign cfg.long_press_samples = long_press_r;

endmodule

`default_nettype wire

[design/kdlp_core.sv]
// ----------------------------------------------------------------------------
// kdlp_core
// tick counter and four-phase debounce machine, one tick per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          tick_en,
  input  wire logic [kdlp_pkg::MASK_W-1:0]   key_mask,
  input  wire kdlp_pkg::cfg_t                cfg,
  output logic      [kdlp_pkg::EVENT_W-1:0]  event_res,
  output logic      [kdlp_pkg::MASK_W-1:0]   event_keys
);

  logic [kdlp_pkg::PERIOD_W-1:0] tick_count_r, tick_count_nxt;
  logic [kdlp_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [kdlp_pkg::MASK_W-1:0]   held_mask_r, held_mask_nxt;
  logic [kdlp_pkg::LONG_W-1:0]   hold_count_r, hold_count_nxt;

  logic [kdlp_pkg::PERIOD_W:0]   tick_inc;
  logic                          sample;
  logic [kdlp_pkg::MASK_W-1:0]   mask;
  logic                          same;
  logic [kdlp_pkg::LONG_W-1:0]   hold_inc;

  assign mask     = key_mask & kdlp_pkg::KEYS_MASK;
  assign same     = (mask == held_mask_r);
  assign tick_inc = {1'b0, tick_count_r} + 1'b1;
  assign sample   = (tick_inc >= {1'b0, cfg.sample_period});
  assign hold_inc = (hold_count_r != '1) ? hold_count_r + 1'b1 : hold_count_r;

  always_comb begin
    tick_count_nxt = sample ? '0 : tick_inc[kdlp_pkg::PERIOD_W-1:0];
    phase_nxt      = phase_r;
    held_mask_nxt  = held_mask_r;
    hold_count_nxt = hold_count_r;
    event_res      = kdlp_pkg::EV_NONE;
    event_keys     = '0;
    if (sample) begin
      unique case (phase_r)
        kdlp_pkg::PH_IDLE: begin
          if (mask != '0) begin
            held_mask_nxt = mask;
            phase_nxt     = kdlp_pkg::PH_CONFIRM;
          end
        end
        kdlp_pkg::PH_CONFIRM: begin
          if (same) begin
            phase_nxt      = kdlp_pkg::PH_HELD;
            hold_count_nxt = '0;
            event_res      = kdlp_pkg::EV_DOWN;
            event_keys     = held_mask_r;
          end else begin
            phase_nxt = kdlp_pkg::PH_IDLE;
          end
        end
        kdlp_pkg::PH_HELD: begin
          if (!same) begin
            phase_nxt      = kdlp_pkg::PH_IDLE;
            hold_count_nxt = '0;
            event_res      = kdlp_pkg::EV_UP;
            event_keys     = held_mask_r;
          end else if (hold_inc >= cfg.long_press_samples) begin
            phase_nxt      = kdlp_pkg::PH_WAIT;
            hold_count_nxt = '0;
            event_res      = kdlp_pkg::EV_LONG;
            event_keys     = mask;
          end else begin
            hold_count_nxt = hold_inc;
          end
        end
        kdlp_pkg::PH_WAIT: begin
          if (!same) begin
            phase_nxt = kdlp_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = kdlp_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      phase_r      <= kdlp_pkg::PH_IDLE;
      held_mask_r  <= '0;
      hold_count_r <= '0;
    end else if (tick_en) begin
      tick_count_r <= tick_count_nxt;
      phase_r      <= phase_nxt;
      held_mask_r  <= held_mask_nxt;
      hold_count_r <= hold_count_nxt;
    end
  end

endmodule

`default_nettype wire

[design/key_debounce_long_press_unit.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit
// key debouncer with down, up and long press events on a stream interface
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick carrying the raw key mask; each
// tick yields exactly one output transaction, passed through the input and
// output registers, with event code zero when nothing happened. The unit
// takes one tick per clock cycle while the output is not stalled, a rate set
// by the combinational update of tick counter and debounce state between the
// two registers. The user must write sample period and long press count over
// the apb port only while no tick is in flight; the unit does not enforce it.
`default_nettype none

module key_debounce_long_press_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [kdlp_pkg::TDATA_W-1:0]      in_tdata,   // [2:0] key_mask
  // output stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [kdlp_pkg::TDATA_W-1:0]      out_tdata,  // [2:0] event_keys
  output logic      [kdlp_pkg::EVENT_W-1:0]      out_tuser,  // [1:0] event_res
  // configuration
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [kdlp_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [kdlp_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic      [kdlp_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  kdlp_pkg::cfg_t                 cfg;
  logic                           s1_valid_r;
  logic [kdlp_pkg::MASK_W-1:0]    s1_mask_r;
  logic                           out_valid_r;
  logic [kdlp_pkg::MASK_W-1:0]    out_keys_r;
  logic [kdlp_pkg::EVENT_W-1:0]   out_ev_r;
  logic                           out_adv;
  logic                           fire;
  logic [kdlp_pkg::EVENT_W-1:0]   ev;
  logic [kdlp_pkg::MASK_W-1:0]    ev_keys;

  assign cfg_pready = 1'b1;

  kdlp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign out_adv   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mask_r <= in_tdata[kdlp_pkg::MASK_W-1:0];
    end
  end

  kdlp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (fire),
    .key_mask   (s1_mask_r),
    .cfg        (cfg),
    .event_res  (ev),
    .event_keys (ev_keys)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ev_r   <= ev;
      out_keys_r <= ev_keys;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = kdlp_pkg::TDATA_W'(out_keys_r);
  assign out_tuser  = out_ev_r;

endmodule

`default_nettype wire

[verif/key_debounce_long_press_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit_test
// stream and apb testbench for the key debounce and long press unit
// ----------------------------------------------------------------------------
// Feeds timer ticks carrying raw key masks: a short directed run over down,
// up, long press, bounce and the zero period and zero count settings, then
// random press and release sequences with bounce and noise mixed in. Every
// accepted tick is run through a cycle-free debounce predictor and each
// output transaction is compared against the oldest predicted event. Both
// stream sides idle at random, and the receiver once holds off long enough
// to back up the input.
`default_nettype none

module key_debounce_long_press_unit_test;
  import kdlp_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 6;
  localparam int unsigned TIMEOUT_NS    = 12 * 300000;
  localparam int unsigned LONG_STALL    = 300;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [EVENT_W-1:0] ev;
    logic [MASK_W-1:0]  keys;
  } key_event_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [TDATA_W-1:0]      in_tdata    = '0;
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  logic [TDATA_W-1:0]      out_tdata;
  logic [EVENT_W-1:0]      out_tuser;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [APB_DATA_W-1:0]   cfg_pwdata  = '0;
  logic [APB_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  // predictor state and configuration
  logic [PERIOD_W-1:0]     period_cfg  = SAMPLE_PERIOD_RST;
  logic [LONG_W-1:0]       long_cfg    = LONG_PRESS_RST;
  logic [PERIOD_W-1:0]     tick_cnt    = '0;
  logic [PHASE_W-1:0]      key_phase   = PH_IDLE;
  logic [MASK_W-1:0]       held_keys   = '0;
  logic [LONG_W-1:0]       hold_cnt    = '0;

  logic [MASK_W-1:0]       tick_queue[$];
  key_event_t              event_expect_q[$];
  int unsigned             ticks_sent     = 0;
  int unsigned             ticks_taken    = 0;
  int unsigned             fail_count     = 0;
  int unsigned             send_idle_pct  = 0;
  int unsigned             recv_idle_pct  = 0;
  int unsigned             stall_requests = 0;
  int unsigned             stall_served   = 0;
  int unsigned             stall_left     = 0;
  logic                    in_taken       = 1'b0;

  key_debounce_long_press_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [2:0] key_mask
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [2:0] event_keys
    .out_tuser  (out_tuser),   // [1:0] event_res
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  function automatic key_event_t debounce_tick(logic [MASK_W-1:0] raw);
    key_event_t      r;
    logic [MASK_W-1:0] m;
    int unsigned     nxt;
    m = raw & KEYS_MASK;
    r.ev = EV_NONE;
    r.keys = '0;
    nxt = tick_cnt + 1;
    if (nxt >= period_cfg) begin
      tick_cnt = '0;
      case (key_phase)
        PH_IDLE: begin
          if (m != '0) begin
            held_keys = m;
            key_phase = PH_CONFIRM;
          end
        end
        PH_CONFIRM: begin
          if (m == held_keys) begin
            key_phase = PH_HELD;
            hold_cnt = '0;
            r.ev = EV_DOWN;
            r.keys = held_keys;
          end else begin
            key_phase = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (m != held_keys) begin
            key_phase = PH_IDLE;
            hold_cnt = '0;
            r.ev = EV_UP;
            r.keys = held_keys;
          end else begin
            if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
            if (hold_cnt >= long_cfg) begin
              hold_cnt = '0;
              key_phase = PH_WAIT;
              r.ev = EV_LONG;
              r.keys = m;
            end
          end
        end
        default: begin
          if (m != held_keys) key_phase = PH_IDLE;
        end
      endcase
    end else begin
      tick_cnt = nxt[PERIOD_W-1:0];
    end
    return r;
  endfunction

  // tick driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(TDATA_W-MASK_W){1'b0}}, tick_queue.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // event receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_tready <= 1'b0;
      end else if (stall_served != stall_requests) begin
        stall_served = stall_served + 1;
        stall_left = LONG_STALL;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n) begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        event_expect_q.push_back(debounce_tick(in_tdata[MASK_W-1:0]));
        ticks_taken = ticks_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (event_expect_q.size() == 0) begin
          $display("%0t: unexpected event transaction, expected none, got event %0d data %0h",
                   $time, out_tuser, out_tdata);
          fail_count = fail_count + 1;
        end else begin
          want = event_expect_q.pop_front();
          if (out_tuser !== want.ev ||
              out_tdata !== {{(TDATA_W-MASK_W){1'b0}}, want.keys}) begin
            $display("%0t: event mismatch, expected event %0d keys %0h, got event %0d data %0h",
                     $time, want.ev, want.keys, out_tuser, out_tdata);
            fail_count = fail_count + 1;
          end
        end
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  task automatic write_reg(logic reg_idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] want;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {reg_idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    if (reg_idx == REG_SAMPLE_PERIOD) begin
      period_cfg = value[PERIOD_W-1:0];
      want = APB_DATA_W'(period_cfg);
    end else begin
      long_cfg = value[LONG_W-1:0];
      want = APB_DATA_W'(long_cfg);
    end
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, reg_idx, want, cfg_prdata);
      fail_count = fail_count + 1;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_config(int unsigned period, int unsigned long_count);
    write_reg(REG_SAMPLE_PERIOD, period);
    write_reg(REG_LONG_PRESS, long_count);
  endtask

  task automatic wait_idle();
    while (ticks_taken != ticks_sent || event_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_ticks(logic [MASK_W-1:0] mask, int unsigned reps, int unsigned stop_at);
    while (reps > 0 && ticks_sent < stop_at) begin
      tick_queue.push_back(mask);
      ticks_sent = ticks_sent + 1;
      reps = reps - 1;
    end
  endtask

  task automatic push_list(logic [MASK_W-1:0] masks[]);
    foreach (masks[i]) push_ticks(masks[i], 1, ticks_sent + 1);
  endtask

  // mostly clean press and release sequences, some bounce and noise
  task automatic queue_key_activity(int unsigned n_ticks);
    int unsigned     stop_at;
    int unsigned     spacing;
    int unsigned     pick;
    int unsigned     hold_lim;
    logic [MASK_W-1:0] m;
    logic [MASK_W-1:0] m2;
    stop_at = ticks_sent + n_ticks;
    spacing = (period_cfg == 0) ? 1 : period_cfg;
    hold_lim = (long_cfg > 20) ? 20 : long_cfg;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        m = MASK_W'($urandom_range(7, 1));
        push_ticks(m, $urandom_range(hold_lim + 3, 1) * spacing + $urandom_range(spacing - 1, 0),
                   stop_at);
        if ($urandom_range(99) < 30) begin
          m2 = MASK_W'($urandom_range(7, 1));
          push_ticks(m2, $urandom_range(4, 2) * spacing, stop_at);
        end
        push_ticks('0, $urandom_range(4, 1) * spacing, stop_at);
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) push_ticks(MASK_W'($urandom_range(7, 0)), 1, stop_at);
      end else begin
        repeat ($urandom_range(10, 1)) push_ticks(MASK_W'($urandom_range(7, 0)), 1, stop_at);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 86;
    set_config(1, 3);
    // down, hold to long press, wait, failed confirm, up, re-press
    push_list('{3'd0, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd0, 3'd1, 3'd2,
                3'd4, 3'd4, 3'd6, 3'd6, 3'd6, 3'd0, 3'd3, 3'd3});
    wait_idle();
    // zero period samples every tick, zero count fires on first equal sample
    set_config(0, 0);
    push_list('{3'd5, 3'd5, 3'd5, 3'd0});
    wait_idle();
    set_config(1, 4);
    queue_key_activity(150);
    wait_idle();
    set_config(255, 65535);
    queue_key_activity(190);
    wait_idle();

    // sender idles heavily, receiver lightly
    send_idle_pct = 86;
    recv_idle_pct = 28;
    set_config(0, 0);
    queue_key_activity(120);
    wait_idle();
    set_config(3, 1);
    queue_key_activity(120);
    wait_idle();

    // no idling, one long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(2, 7);
    stall_requests = stall_requests + 1;
    queue_key_activity(150);
    wait_idle();
    set_config(1, 2);
    queue_key_activity(100);
    wait_idle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
